>>> design/timestamp_to_calendar_date_macros.svh
// Assertion macros for the timestamp to calendar date block
`ifndef TIMESTAMP_TO_CALENDAR_DATE_MACROS_SVH
`define TIMESTAMP_TO_CALENDAR_DATE_MACROS_SVH

`ifndef SYNTH
`define TTCD_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ttcd assertion failed");
`define TTCD_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ttcd assertion failed");
`else
`define TTCD_ASSERT_RST(lbl, clk, rst, prop)
`define TTCD_ASSERT(lbl, clk, prop)
`endif

`endif

>>> design/ttcd_pkg.sv
// Shared types, constants and helper functions for the calendar date converter
package ttcd_pkg;

  typedef enum logic [3:0] {
    OP_BACK, OP_REM, OP_FIX, OP_DAYS, OP_SOD, OP_HOUR, OP_MREM, OP_MIN, OP_SEC,
    OP_YEAR, OP_MONTH, OP_DONE
  } op_t;
  typedef enum logic [1:0] {COND_NS_FIT, COND_YEAR_FIT, COND_MONTH_FIT, COND_ALWAYS} cond_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_BACK  = 4'd0;
  localparam step_t STEP_REM   = 4'd1;
  localparam step_t STEP_FIX   = 4'd2;
  localparam step_t STEP_DAYS  = 4'd3;
  localparam step_t STEP_SOD   = 4'd4;
  localparam step_t STEP_HOUR  = 4'd5;
  localparam step_t STEP_MREM  = 4'd6;
  localparam step_t STEP_MIN   = 4'd7;
  localparam step_t STEP_SEC   = 4'd8;
  localparam step_t STEP_YEAR  = 4'd9;
  localparam step_t STEP_MONTH = 4'd10;
  localparam step_t STEP_DONE  = 4'd11;

  typedef struct packed {
    op_t      op;
    cond_t    cond;
    step_t    exit_step;
  } ucode_t;

  typedef struct packed {
    logic   load;
    logic   run;
    ucode_t uc;
  } dp_ctrl_t;

  typedef struct packed {
    logic ns_fit;
    logic year_fit;
    logic month_fit;
  } dp_flags_t;

  localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
  // floor(2^61 / 1e9): seconds estimate from the upper timestamp word
  localparam logic [31:0] NS_RECIP      = 32'd2305843009;
  // 1e9 = 2^9 * 5^9
  localparam logic [20:0] NS_ODD        = 21'd1953125;
  // 86400 = 2^7 * 675, ceil(2^38 / 675) exact for 28-bit operands
  localparam logic [28:0] DAY_RECIP     = 29'd407226529;
  localparam logic [9:0]  DAY_ODD       = 10'd675;
  // 3600 = 2^4 * 225, ceil(2^21 / 225)
  localparam logic [13:0] HOUR_RECIP    = 14'd9321;
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  // 60 = 2^2 * 15, ceil(2^14 / 15)
  localparam logic [10:0] MIN_RECIP     = 11'd1093;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd3;
  localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
  localparam logic [3:0]  MONTH_LAST    = 4'd11;
  localparam logic [3:0]  MONTH_FEB     = 4'd1;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: return 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   return 5'd30;
      MONTH_FEB:                                 return leap ? 5'd29 : 5'd28;
      default:                                   return 5'd31;
    endcase
  endfunction

  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= 6'd7) r = r - 6'd7;
    end
    return r[2:0];
  endfunction

endpackage

>>> design/timestamp_to_calendar_date.sv
// Steps: back-multiply, remainder, seconds fix (0..7 corrections), days, seconds of day,
//   hour, minute remainder, minute, second, a year step per year past 1970 (0..584),
//   a month step per whole month passed in the last year (0..11), then done.
// One item at a time; busy drops with the one-cycle strobe, so the next item can be accepted
//   at the edge ending the strobe cycle.
// Synchronous active-high reset idles the sequencer and clears done; no other state.
`include "timestamp_to_calendar_date_macros.svh"
module timestamp_to_calendar_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] timestamp_ns,
  output logic        done,
  output logic [11:0] year_out,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [2:0]  weekday,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out,
  output logic [29:0] nanosecond_out
);
  import ttcd_pkg::*;

  dp_ctrl_t  ctrl;
  dp_flags_t flags;

  ttcd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  ttcd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .timestamp_ns   (timestamp_ns),
    .flags          (flags),
    .done           (done),
    .year_out       (year_out),
    .month_index    (month_index),
    .day_of_month   (day_of_month),
    .weekday        (weekday),
    .hour_out       (hour_out),
    .minute_out     (minute_out),
    .second_out     (second_out),
    .nanosecond_out (nanosecond_out)
  );

  `TTCD_ASSERT_RST(a_accept_busy, clk, rst, start && !busy |=> busy)
  `TTCD_ASSERT_RST(a_done_single, clk, rst, done |=> !done)
  `TTCD_ASSERT_RST(a_done_idle, clk, rst, done |-> !busy)
  `TTCD_ASSERT_RST(a_done_after_busy, clk, rst, done |-> $past(busy))

endmodule

>>> design/ttcd_seq.sv
// Microcode sequencer: step counter, control store and jump logic
module ttcd_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ttcd_pkg::dp_flags_t flags,
  output logic                busy,
  output ttcd_pkg::dp_ctrl_t  ctrl
);
  import ttcd_pkg::*;

  step_t  step;
  ucode_t uc;
  logic   cond_met;

  always_comb begin
    case (step)
      STEP_BACK:  uc = '{OP_BACK,  COND_ALWAYS,    STEP_REM};
      STEP_REM:   uc = '{OP_REM,   COND_ALWAYS,    STEP_FIX};
      STEP_FIX:   uc = '{OP_FIX,   COND_NS_FIT,    STEP_DAYS};
      STEP_DAYS:  uc = '{OP_DAYS,  COND_ALWAYS,    STEP_SOD};
      STEP_SOD:   uc = '{OP_SOD,   COND_ALWAYS,    STEP_HOUR};
      STEP_HOUR:  uc = '{OP_HOUR,  COND_ALWAYS,    STEP_MREM};
      STEP_MREM:  uc = '{OP_MREM,  COND_ALWAYS,    STEP_MIN};
      STEP_MIN:   uc = '{OP_MIN,   COND_ALWAYS,    STEP_SEC};
      STEP_SEC:   uc = '{OP_SEC,   COND_ALWAYS,    STEP_YEAR};
      STEP_YEAR:  uc = '{OP_YEAR,  COND_YEAR_FIT,  STEP_MONTH};
      STEP_MONTH: uc = '{OP_MONTH, COND_MONTH_FIT, STEP_DONE};
      STEP_DONE:  uc = '{OP_DONE,  COND_ALWAYS,    STEP_BACK};
      default:    uc = '{OP_DONE,  COND_ALWAYS,    STEP_BACK};
    endcase
  end

  always_comb begin
    case (uc.cond)
      COND_NS_FIT:    cond_met = flags.ns_fit;
      COND_YEAR_FIT:  cond_met = flags.year_fit;
      COND_MONTH_FIT: cond_met = flags.month_fit;
      COND_ALWAYS:    cond_met = 1'b1;
      default:        cond_met = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_BACK;
    end else if (start && !busy) begin
      busy <= 1'b1;
      step <= STEP_BACK;
    end else if (busy && cond_met) begin
      step <= uc.exit_step;
      if (uc.op == OP_DONE) busy <= 1'b0;
    end
  end

  assign ctrl.load = start && !busy;
  assign ctrl.run  = busy;
  assign ctrl.uc   = uc;

endmodule

>>> design/ttcd_dp.sv
// Datapath: reciprocal splitting of the timestamp, year and month stepping, weekday tracking
module ttcd_dp (
  input  logic                clk,
  input  logic                rst,
  input  ttcd_pkg::dp_ctrl_t  ctrl,
  input  logic [63:0]         timestamp_ns,
  output ttcd_pkg::dp_flags_t flags,
  output logic                done,
  output logic [11:0]         year_out,
  output logic [3:0]          month_index,
  output logic [4:0]          day_of_month,
  output logic [2:0]          weekday,
  output logic [4:0]          hour_out,
  output logic [5:0]          minute_out,
  output logic [5:0]          second_out,
  output logic [29:0]         nanosecond_out
);
  import ttcd_pkg::*;

  logic [34:0] q;
  logic [35:0] ts_lo;
  logic [26:0] p;
  logic [35:0] r;
  logic [17:0] days;
  logic [16:0] sod;
  logic [11:0] rmin;
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hr;
  logic [11:0] year;
  logic [1:0]  y4;
  logic [6:0]  y100;
  logic [8:0]  y400;
  logic [2:0]  wd;
  logic [3:0]  mon;

  logic [63:0] recip_prod;
  logic [26:0] back_prod;
  logic [56:0] day_prod;
  logic [27:0] day_back;
  logic [26:0] hour_prod;
  logic [16:0] hour_back;
  logic [20:0] min_prod;
  logic [11:0] min_back;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [3:0]  wd_y;
  logic [3:0]  wd_m;
  logic [2:0]  wd_final;

  always_comb begin
    // seconds estimate, low by at most 7; the fix step corrects it
    recip_prod = {32'd0, timestamp_ns[63:32]} * {32'd0, NS_RECIP};
    // only the low 36 bits of estimate * 1e9 are needed for the remainder
    back_prod  = q[26:0] * {6'd0, NS_ODD};
    day_prod   = {29'd0, q[34:7]} * {28'd0, DAY_RECIP};
    day_back   = {10'd0, days} * {18'd0, DAY_ODD};
    hour_prod  = {14'd0, sod[16:4]} * {13'd0, HOUR_RECIP};
    hour_back  = {12'd0, hr} * {5'd0, SEC_PER_HOUR};
    min_prod   = {11'd0, rmin[11:2]} * {10'd0, MIN_RECIP};
    min_back   = {6'd0, min} * {6'd0, SEC_PER_MIN};

    leap = ((y4 == 2'd0) && (y100 != 7'd0)) || (y400 == 9'd0);
    ylen = leap ? 9'd366 : 9'd365;
    mlen = month_len(mon, leap);

    wd_y = {1'b0, wd} + (leap ? 4'd2 : 4'd1);
    if (wd_y >= 4'd7) wd_y = wd_y - 4'd7;
    wd_m = {1'b0, wd} + {2'b00, 2'(mlen - 5'd28)};
    if (wd_m >= 4'd7) wd_m = wd_m - 4'd7;
    wd_final = mod7({3'b000, wd} + {1'b0, days[4:0]});

    flags.ns_fit    = r < {6'd0, NS_PER_SEC};
    flags.year_fit  = days < {9'd0, ylen};
    flags.month_fit = (mon == MONTH_LAST) || (days < {13'd0, mlen});
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q     <= recip_prod[63:29];
      ts_lo <= timestamp_ns[35:0];
      year  <= EPOCH_YEAR;
      y4    <= EPOCH_MOD4;
      y100  <= EPOCH_MOD100;
      y400  <= EPOCH_MOD400;
      wd    <= EPOCH_WEEKDAY;
      mon   <= '0;
    end else if (ctrl.run) begin
      case (ctrl.uc.op)
        OP_BACK: p <= back_prod;
        OP_REM:  r <= ts_lo - {p, 9'd0};
        OP_FIX: begin
          if (!flags.ns_fit) begin
            r <= r - {6'd0, NS_PER_SEC};
            q <= q + 35'd1;
          end
        end
        OP_DAYS: days <= day_prod[55:38];
        OP_SOD:  sod  <= {10'(q[34:7] - day_back), q[6:0]};
        OP_HOUR: hr   <= hour_prod[25:21];
        OP_MREM: rmin <= 12'(sod - hour_back);
        OP_MIN:  min  <= min_prod[19:14];
        OP_SEC:  sec  <= 6'(rmin - min_back);
        OP_YEAR: begin
          if (!flags.year_fit) begin
            days <= days - {9'd0, ylen};
            year <= year + 12'd1;
            y4   <= y4 + 2'd1;
            y100 <= (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
            y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
            wd   <= wd_y[2:0];
          end
        end
        OP_MONTH: begin
          if (!flags.month_fit) begin
            days <= days - {13'd0, mlen};
            mon  <= mon + 4'd1;
            wd   <= wd_m[2:0];
          end
        end
        OP_DONE: wd <= wd_final;
        default: wd <= wd;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.run && (ctrl.uc.op == OP_DONE);
    end
  end

  assign year_out       = year;
  assign month_index    = mon;
  assign day_of_month   = days[4:0] + 5'd1;
  assign weekday        = wd;
  assign hour_out       = hr;
  assign minute_out     = min;
  assign second_out     = sec;
  assign nanosecond_out = r[29:0];

endmodule

>>> tb/timestamp_to_calendar_date_tb.sv
// Testbench for timestamp_to_calendar_date: directed and random timestamps checked by a date predictor
`timescale 1ns / 100ps

module timestamp_to_calendar_date_tb;

  localparam longint unsigned NS_IN_SEC  = 64'd1_000_000_000;
  localparam longint unsigned SEC_IN_DAY = 64'd86_400;
  localparam int unsigned     N_RANDOM   = 905;

  typedef struct {
    logic [63:0] ts;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] nsec;
  } civil_time_t;

  typedef struct {
    logic [63:0] ts;
    int unsigned gap_after;
    bit          wait_idle;
  } ts_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [63:0] timestamp_ns = '0;
  logic        busy;
  logic        done;
  logic [11:0] year_out;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;
  logic [2:0]  weekday;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;
  logic [29:0] nanosecond_out;

  ts_item_t    to_send[$];
  civil_time_t dates_due[$];
  civil_time_t got_date;
  int unsigned gap_left = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_directed = 0;
  int unsigned n_total = 0;
  int unsigned n_leap_days = 0;
  int unsigned year_lo = 4095;
  int unsigned year_hi = 0;

  timestamp_to_calendar_date i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .timestamp_ns  (timestamp_ns),
    .done          (done),
    .year_out      (year_out),
    .month_index   (month_index),
    .day_of_month  (day_of_month),
    .weekday       (weekday),
    .hour_out      (hour_out),
    .minute_out    (minute_out),
    .second_out    (second_out),
    .nanosecond_out(nanosecond_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit is_leap(input int unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic int unsigned year_days(input int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    case (m)
      1:           return is_leap(y) ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic civil_time_t civil_time_of(input logic [63:0] ts);
    civil_time_t     r;
    longint unsigned secs;
    longint unsigned days;
    int unsigned     yr;
    int unsigned     mon;
    r.ts     = ts;
    r.nsec   = 30'(ts % NS_IN_SEC);
    secs     = ts / NS_IN_SEC;
    r.second = 6'(secs % 60);
    secs     = secs / 60;
    r.minute = 6'(secs % 60);
    secs     = secs / 60;
    r.hour   = 5'(secs % 24);
    days     = secs / 24;
    // 1 January 1970 was a Thursday
    r.wday   = 3'((days + 3) % 7);
    yr = 1970;
    while (days >= year_days(yr)) begin
      days -= year_days(yr);
      yr++;
    end
    mon = 0;
    while (mon < 11 && days >= month_days(yr, mon)) begin
      days -= month_days(yr, mon);
      mon++;
    end
    r.year  = 12'(yr);
    r.month = 4'(mon);
    r.mday  = 5'(days + 1);
    return r;
  endfunction

  function automatic logic [63:0] ts_of(input int unsigned y, input int unsigned m,
                                        input int unsigned d, input longint unsigned sod,
                                        input longint unsigned ns);
    longint unsigned days;
    days = d - 1;
    for (int unsigned i = 1970; i < y; i++) days += year_days(i);
    for (int unsigned i = 0; i < m; i++) days += month_days(y, i);
    return (days * SEC_IN_DAY + sod) * NS_IN_SEC + ns;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(100, 300);
  endfunction

  task automatic add_ts(input logic [63:0] ts, input bit wait_idle);
    ts_item_t it;
    it.ts        = ts;
    it.wait_idle = wait_idle;
    // every third block of 60 items runs back to back
    it.gap_after = ((to_send.size() / 60) % 3 == 2) ? 0 : pick_gap();
    to_send.push_back(it);
    n_total++;
  endtask

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want, input logic [63:0] ts);
    if (got != want)
      flag_mismatch($sformatf("%s for ts %0d: got %0d, expected %0d", name, ts, got, want));
  endtask

  function automatic logic [63:0] random_ts();
    int unsigned     y;
    int unsigned     m;
    longint unsigned base;
    longint unsigned days;
    longint unsigned sod;
    longint unsigned ns;
    int unsigned     kind;
    kind = $urandom_range(0, 99);
    sod  = $urandom_range(0, 86399);
    ns   = $urandom_range(0, 999_999_999);
    if (kind < 30) return {$urandom, $urandom};
    if (kind < 55) begin
      // month and year boundaries
      y    = $urandom_range(1970, 2553);
      m    = $urandom_range(0, 11);
      base = ts_of(y, m, 1, 0, 0);
      case ($urandom_range(0, 3))
        0:       return base;
        1:       return (base == 0) ? base : base - 1;
        2:       return base + sod * NS_IN_SEC + ns;
        default: return ts_of(y, m, month_days(y, m), 86399, 999_999_999);
      endcase
    end
    if (kind < 80) days = $urandom_range(0, 213502);
    else days = $urandom_range(0, 1500);
    return (days * SEC_IN_DAY + sod) * NS_IN_SEC + ns;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        dates_due.push_back(civil_time_of(timestamp_ns));
        n_accepted++;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (to_send.size() != 0 && !(to_send[0].wait_idle && dates_due.size() != 0)) begin
          timestamp_ns <= to_send[0].ts;
          gap_left     <= to_send[0].gap_after;
          start        <= 1'b1;
          void'(to_send.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (dates_due.size() == 0) begin
        flag_mismatch("result strobe with no item outstanding");
      end else begin
        got_date = dates_due.pop_front();
        check_field("year_out", year_out, got_date.year, got_date.ts);
        check_field("month_index", month_index, got_date.month, got_date.ts);
        check_field("day_of_month", day_of_month, got_date.mday, got_date.ts);
        check_field("weekday", weekday, got_date.wday, got_date.ts);
        check_field("hour_out", hour_out, got_date.hour, got_date.ts);
        check_field("minute_out", minute_out, got_date.minute, got_date.ts);
        check_field("second_out", second_out, got_date.second, got_date.ts);
        check_field("nanosecond_out", nanosecond_out, got_date.nsec, got_date.ts);
        n_checked++;
        if (got_date.year < year_lo) year_lo = got_date.year;
        if (got_date.year > year_hi) year_hi = got_date.year;
        if (got_date.month == 1 && got_date.mday == 29) n_leap_days++;
      end
    end
  end

  initial begin
    add_ts(64'd0, 1'b0);
    add_ts(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    add_ts(64'd999_999_999, 1'b0);
    add_ts(64'd59_999_999_999, 1'b0);
    add_ts(ts_of(1970, 0, 1, 86399, 999_999_999), 1'b0);
    add_ts(ts_of(1970, 0, 2, 0, 0), 1'b0);
    add_ts(ts_of(1970, 11, 31, 86399, 999_999_999), 1'b0);
    add_ts(ts_of(1972, 1, 29, 0, 0), 1'b0);
    add_ts(ts_of(1972, 2, 1, 0, 0), 1'b0);
    add_ts(ts_of(1972, 11, 31, 86399, 999_999_999), 1'b0);
    add_ts(ts_of(2000, 1, 29, 43200, 500_000_000), 1'b0);
    add_ts(ts_of(2100, 1, 28, 86399, 999_999_999), 1'b0);
    add_ts(ts_of(2100, 2, 1, 0, 0), 1'b0);
    add_ts(ts_of(2400, 1, 29, 3661, 1), 1'b0);
    add_ts(ts_of(2400, 11, 31, 86399, 999_999_999), 1'b0);
    add_ts(ts_of(2554, 0, 1, 0, 0), 1'b0);
    add_ts(64'h8000_0000_0000_0000, 1'b0);
    add_ts(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    add_ts(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_ts(64'h5555_5555_5555_5555, 1'b0);
    n_directed = n_total;
    for (int unsigned i = 0; i < N_RANDOM; i++)
      add_ts(random_ts(), (i == 0) || (i == N_RANDOM / 2) || (i == N_RANDOM - 100));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total || dates_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Checked %0d conversions (%0d directed, %0d random), years %0d to %0d reached,",
             n_checked, n_directed, n_total - n_directed, year_lo, year_hi);
    $display("%0d of them on 29 February, %0d mismatches", n_leap_days, n_errors);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timeout: %0d of %0d items accepted, %0d results outstanding",
             n_accepted, n_total, dates_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
